// File: rtl/dlas_pkg.sv
// dlas_pkg: types, codes and reset constants for the drop launch arming sequencer
// used by dlas_step and drop_launch_arming_sequencer_unit; no dependencies
package dlas_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_AUTH    = 3'd1,
		MODE_RELWAIT = 3'd2,
		MODE_ARMACQ  = 3'd3,
		MODE_HOVER   = 3'd4,
		MODE_ARMED   = 3'd5,
		MODE_HANDOFF = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ACT_UPDATE  = 2'd0,
		ACT_AUTH    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_ABORT   = 2'd3
	} action_t;

	localparam int unsigned ThreshW = 14;
	localparam int unsigned SpanW   = 31;
	localparam int unsigned RateW   = 12;
	localparam int unsigned TimeW   = 32;

	typedef enum logic [1:0] {
		REG_FF_THRESH  = 2'd0,
		REG_FF_CONFIRM = 2'd1,
		REG_HOVER_SPAN = 2'd2,
		REG_RATE_LIMIT = 2'd3
	} reg_idx_t;

	localparam logic [ThreshW-1:0] FfThreshReset  = 14'd300;
	localparam logic [SpanW-1:0]   FfConfirmReset = 31'd100000;
	localparam logic [SpanW-1:0]   HoverSpanReset = 31'd500000;
	localparam logic [RateW-1:0]   RateLimitReset = 12'd30;

	typedef struct packed {
		logic [ThreshW-1:0] ff_thresh;
		logic [SpanW-1:0]   ff_confirm;
		logic [SpanW-1:0]   hover_span;
		logic [RateW-1:0]   rate_limit;
	} cfg_t;

	typedef struct packed {
		action_t            action;
		logic [TimeW-1:0]   now_us;
		logic               armed;
		logic               failsafe;
		logic               accel_valid;
		logic [ThreshW-1:0] accel_mag;
		logic [RateW-1:0]   roll_rate;
		logic [RateW-1:0]   pitch_rate;
		logic [RateW-1:0]   yaw_rate;
		logic               arm_try_ok;
	} item_t;

	typedef struct packed {
		mode_t            mode;
		logic             ff_pending;
		logic [TimeW-1:0] ff_start;
		logic             hv_pending;
		logic [TimeW-1:0] hv_start;
	} state_t;

	typedef struct packed {
		logic  arm_request;
		logic  suppress_pilot_hold;
		logic  wants_alt_pos_hold;
		logic  wants_angle;
		logic  suppress_pilot_input;
		logic  owns_arming;
		logic  accepted;
		mode_t mode;
	} result_t;

endpackage

// File: rtl/drop_launch_arming_sequencer_unit.sv
// drop_launch_arming_sequencer_unit: top level of the drop launch arming sequencer
// holds input, state and result registers; depends on dlas_pkg and dlas_step
//
// Each accepted input word is registered, run through combinational compare and
// subtract logic against the held mode and timers, and its single result word is
// registered on the master side. One word is accepted per clock unless both
// registers are full and the master side stalls. While a result waits, one
// more word can be held in the input register before the input side stalls.
// Mode and timer state advance only when a word passes the step logic, so
// results keep input order. Configuration writes apply on the next clock and
// should be made while idle.
module drop_launch_arming_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [30:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_us[31:0], armed, failsafe, accel_valid, accel_magnitude_mg[13:0],
	// roll_rate_dps[11:0], pitch_rate_dps[11:0], yaw_rate_dps[11:0], arm_try_ok, zero pad
	input  logic [87:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mode[2:0], accepted, owns_arming, suppress_pilot_input, wants_angle,
	// wants_alt_pos_hold, suppress_pilot_hold, arm_request, zero pad
	output logic [15:0] m_tdata
);

	dlas_pkg::cfg_t    cfg_q;
	dlas_pkg::state_t  state_q;
	dlas_pkg::state_t  state_nxt;
	dlas_pkg::item_t   item_s1;
	dlas_pkg::item_t   item_in;
	dlas_pkg::result_t res;
	dlas_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	assign item_in.action      = dlas_pkg::action_t'(s_tuser);
	assign item_in.now_us      = s_tdata[31:0];
	assign item_in.armed       = s_tdata[32];
	assign item_in.failsafe    = s_tdata[33];
	assign item_in.accel_valid = s_tdata[34];
	assign item_in.accel_mag   = s_tdata[48:35];
	assign item_in.roll_rate   = s_tdata[60:49];
	assign item_in.pitch_rate  = s_tdata[72:61];
	assign item_in.yaw_rate    = s_tdata[84:73];
	assign item_in.arm_try_ok  = s_tdata[85];

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ff_thresh  <= dlas_pkg::FfThreshReset;
			cfg_q.ff_confirm <= dlas_pkg::FfConfirmReset;
			cfg_q.hover_span <= dlas_pkg::HoverSpanReset;
			cfg_q.rate_limit <= dlas_pkg::RateLimitReset;
		end else if (cfg_wr_en) begin
			unique case (dlas_pkg::reg_idx_t'(cfg_addr))
				dlas_pkg::REG_FF_THRESH:  cfg_q.ff_thresh  <= cfg_wdata[dlas_pkg::ThreshW-1:0];
				dlas_pkg::REG_FF_CONFIRM: cfg_q.ff_confirm <= cfg_wdata[dlas_pkg::SpanW-1:0];
				dlas_pkg::REG_HOVER_SPAN: cfg_q.hover_span <= cfg_wdata[dlas_pkg::SpanW-1:0];
				dlas_pkg::REG_RATE_LIMIT: cfg_q.rate_limit <= cfg_wdata[dlas_pkg::RateW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	dlas_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= dlas_pkg::MODE_IDLE;
			state_q.ff_pending <= 1'b0;
			state_q.ff_start   <= '0;
			state_q.hv_pending <= 1'b0;
			state_q.hv_start   <= '0;
			valid_s2           <= 1'b0;
		end else if (advance) begin
			state_q  <= state_nxt;
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	a_ff_pending_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ff_pending |-> state_q.mode == dlas_pkg::MODE_RELWAIT)
		else $error("freefall timer running outside release wait");

	a_hv_pending_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hv_pending |->
			(state_q.mode == dlas_pkg::MODE_HOVER || state_q.mode == dlas_pkg::MODE_ARMED))
		else $error("hover timer running outside hover entry or armed");

	a_accepted_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.accepted) |->
			(res_s2.mode == dlas_pkg::MODE_AUTH || res_s2.mode == dlas_pkg::MODE_RELWAIT))
		else $error("accepted command left an unexpected mode");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a word passing");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are full and stalled");

endmodule

// File: rtl/dlas_step.sv
// dlas_step: next-state and result logic for one word of the sequencer
// depends on dlas_pkg
module dlas_step (
	input  dlas_pkg::item_t   item,
	input  dlas_pkg::state_t  st,
	input  dlas_pkg::cfg_t    cfg,
	output dlas_pkg::state_t  nxt,
	output dlas_pkg::result_t res
);

	logic [dlas_pkg::TimeW-1:0] ff_diff;
	logic [dlas_pkg::TimeW-1:0] hv_diff;
	logic                       ff_done;
	logic                       hv_done;
	logic                       rates_high;
	logic                       accel_high;
	logic                       accepted;
	logic                       arm_req;
	dlas_pkg::mode_t            abort_mode;

	assign ff_diff = item.now_us - st.ff_start;
	assign hv_diff = item.now_us - st.hv_start;
	// wrapped difference at or above half range counts as negative
	assign ff_done = !ff_diff[dlas_pkg::TimeW-1] &&
		(ff_diff[dlas_pkg::SpanW-1:0] >= cfg.ff_confirm);
	assign hv_done = !hv_diff[dlas_pkg::TimeW-1] &&
		(hv_diff[dlas_pkg::SpanW-1:0] >= cfg.hover_span);
	assign rates_high = (item.roll_rate > cfg.rate_limit) ||
		(item.pitch_rate > cfg.rate_limit) || (item.yaw_rate > cfg.rate_limit);
	assign accel_high = !item.accel_valid || (item.accel_mag >= cfg.ff_thresh);
	assign abort_mode = (item.armed && st.mode != dlas_pkg::MODE_IDLE) ?
		dlas_pkg::MODE_HANDOFF : dlas_pkg::MODE_IDLE;

	always_comb begin
		nxt      = st;
		accepted = 1'b0;
		arm_req  = 1'b0;
		unique case (item.action)
			dlas_pkg::ACT_AUTH: begin
				if (st.mode == dlas_pkg::MODE_IDLE && !item.armed && !item.failsafe) begin
					nxt.mode = dlas_pkg::MODE_AUTH;
					accepted = 1'b1;
				end
			end
			dlas_pkg::ACT_RELEASE: begin
				if (st.mode == dlas_pkg::MODE_AUTH && !item.armed && !item.failsafe) begin
					nxt.mode       = dlas_pkg::MODE_RELWAIT;
					nxt.ff_pending = 1'b0;
					nxt.ff_start   = '0;
					accepted       = 1'b1;
				end
			end
			dlas_pkg::ACT_ABORT: begin
				nxt.mode       = abort_mode;
				nxt.ff_pending = 1'b0;
				nxt.ff_start   = '0;
				nxt.hv_pending = 1'b0;
				nxt.hv_start   = '0;
			end
			default: begin
				if (item.failsafe) begin
					nxt.mode       = abort_mode;
					nxt.ff_pending = 1'b0;
					nxt.ff_start   = '0;
					nxt.hv_pending = 1'b0;
					nxt.hv_start   = '0;
				end else begin
					unique case (st.mode)
						dlas_pkg::MODE_RELWAIT: begin
							if (accel_high) begin
								nxt.ff_pending = 1'b0;
								nxt.ff_start   = '0;
							end else if (!st.ff_pending) begin
								nxt.ff_pending = 1'b1;
								nxt.ff_start   = item.now_us;
							end else if (ff_done) begin
								nxt.ff_pending = 1'b0;
								nxt.ff_start   = '0;
								if (!item.armed) begin
									nxt.mode = dlas_pkg::MODE_ARMACQ;
								end
							end
						end
						dlas_pkg::MODE_ARMACQ: begin
							arm_req = !item.armed;
							if (item.armed || item.arm_try_ok) begin
								nxt.mode       = dlas_pkg::MODE_HOVER;
								nxt.hv_pending = 1'b0;
								nxt.hv_start   = '0;
							end
						end
						dlas_pkg::MODE_HOVER, dlas_pkg::MODE_ARMED: begin
							if (!item.armed) begin
								nxt.mode       = dlas_pkg::MODE_IDLE;
								nxt.hv_pending = 1'b0;
								nxt.hv_start   = '0;
							end else if (rates_high) begin
								nxt.hv_pending = 1'b0;
								nxt.hv_start   = '0;
							end else if (!st.hv_pending) begin
								nxt.hv_pending = 1'b1;
								nxt.hv_start   = item.now_us;
							end else if (hv_done) begin
								nxt.mode       = dlas_pkg::MODE_ARMED;
								nxt.hv_pending = 1'b0;
								nxt.hv_start   = '0;
							end
						end
						dlas_pkg::MODE_HANDOFF: begin
							if (!item.armed) begin
								nxt.mode = dlas_pkg::MODE_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		res                      = '0;
		res.mode                 = nxt.mode;
		res.accepted             = accepted;
		res.arm_request          = arm_req;
		res.owns_arming          = (nxt.mode == dlas_pkg::MODE_ARMACQ) ||
			(nxt.mode == dlas_pkg::MODE_HOVER) || (nxt.mode == dlas_pkg::MODE_ARMED) ||
			(nxt.mode == dlas_pkg::MODE_HANDOFF);
		res.suppress_pilot_input = (nxt.mode == dlas_pkg::MODE_AUTH) ||
			(nxt.mode == dlas_pkg::MODE_RELWAIT) || (nxt.mode == dlas_pkg::MODE_ARMACQ) ||
			(nxt.mode == dlas_pkg::MODE_HOVER) || (nxt.mode == dlas_pkg::MODE_ARMED);
		res.wants_angle          = (nxt.mode == dlas_pkg::MODE_HOVER) ||
			(nxt.mode == dlas_pkg::MODE_ARMED) || (nxt.mode == dlas_pkg::MODE_HANDOFF);
		res.wants_alt_pos_hold   = (nxt.mode == dlas_pkg::MODE_ARMED);
		res.suppress_pilot_hold  = res.wants_angle;
	end

endmodule

// File: tb/tb_drop_launch_arming_sequencer_unit.sv
// tb_drop_launch_arming_sequencer_unit: self-checking bench for the drop launch arming sequencer
// drives stream words and register writes, predicts each result word in a scoreboard class
// depends on dlas_pkg and drop_launch_arming_sequencer_unit
`timescale 1ns / 100ps

module tb_drop_launch_arming_sequencer_unit;

	localparam int StallLimit = 4000;
	localparam int PhaseItems = 195;

	class seq_scoreboard;
		dlas_pkg::mode_t                      cur_mode;
		bit                                   ff_pend;
		logic [dlas_pkg::TimeW-1:0]           ff_start;
		bit                                   hv_pend;
		logic [dlas_pkg::TimeW-1:0]           hv_start;
		logic [dlas_pkg::ThreshW-1:0]         ff_thr;
		logic [dlas_pkg::SpanW-1:0]           ff_span;
		logic [dlas_pkg::SpanW-1:0]           hv_span;
		logic [dlas_pkg::RateW-1:0]           rate_lim;
		dlas_pkg::result_t                    expected_q[$];
		int                                   errors;

		function new();
			cur_mode = dlas_pkg::MODE_IDLE;
			ff_pend  = 0;
			ff_start = '0;
			hv_pend  = 0;
			hv_start = '0;
			ff_thr   = dlas_pkg::FfThreshReset;
			ff_span  = dlas_pkg::FfConfirmReset;
			hv_span  = dlas_pkg::HoverSpanReset;
			rate_lim = dlas_pkg::RateLimitReset;
			errors   = 0;
		endfunction

		function void write_reg(dlas_pkg::reg_idx_t idx, logic [dlas_pkg::SpanW-1:0] val);
			case (idx)
				dlas_pkg::REG_FF_THRESH:  ff_thr = val[dlas_pkg::ThreshW-1:0];
				dlas_pkg::REG_FF_CONFIRM: ff_span = val;
				dlas_pkg::REG_HOVER_SPAN: hv_span = val;
				dlas_pkg::REG_RATE_LIMIT: rate_lim = val[dlas_pkg::RateW-1:0];
				default: ;
			endcase
		endfunction

		// wrapping signed difference, negative never counts as elapsed
		function bit span_done(logic [dlas_pkg::TimeW-1:0] t,
				logic [dlas_pkg::TimeW-1:0] start, logic [dlas_pkg::SpanW-1:0] span);
			logic [dlas_pkg::TimeW-1:0] d;
			d = t - start;
			return !d[dlas_pkg::TimeW-1] && (d[dlas_pkg::SpanW-1:0] >= span);
		endfunction

		function void clear_ff();
			ff_pend  = 0;
			ff_start = '0;
		endfunction

		function void clear_hv();
			hv_pend  = 0;
			hv_start = '0;
		endfunction

		function void abort_run(bit arm);
			clear_ff();
			clear_hv();
			cur_mode = (arm && cur_mode != dlas_pkg::MODE_IDLE) ?
				dlas_pkg::MODE_HANDOFF : dlas_pkg::MODE_IDLE;
		endfunction

		function void note_input(dlas_pkg::item_t it);
			dlas_pkg::result_t exp;
			bit                acc;
			bit                req;
			acc = 0;
			req = 0;
			case (it.action)
				dlas_pkg::ACT_AUTH: begin
					if (cur_mode == dlas_pkg::MODE_IDLE && !it.armed && !it.failsafe) begin
						cur_mode = dlas_pkg::MODE_AUTH;
						acc = 1;
					end
				end
				dlas_pkg::ACT_RELEASE: begin
					if (cur_mode == dlas_pkg::MODE_AUTH && !it.armed && !it.failsafe) begin
						clear_ff();
						cur_mode = dlas_pkg::MODE_RELWAIT;
						acc = 1;
					end
				end
				dlas_pkg::ACT_ABORT: abort_run(it.armed);
				default: begin
					if (it.failsafe) begin
						abort_run(it.armed);
					end else begin
						case (cur_mode)
							dlas_pkg::MODE_RELWAIT: begin
								if (!it.accel_valid || it.accel_mag >= ff_thr) begin
									clear_ff();
								end else if (!ff_pend) begin
									ff_pend  = 1;
									ff_start = it.now_us;
								end else if (span_done(it.now_us, ff_start, ff_span)) begin
									clear_ff();
									if (!it.armed)
										cur_mode = dlas_pkg::MODE_ARMACQ;
								end
							end
							dlas_pkg::MODE_ARMACQ: begin
								if (it.armed) begin
									clear_hv();
									cur_mode = dlas_pkg::MODE_HOVER;
								end else begin
									req = 1;
									if (it.arm_try_ok) begin
										clear_hv();
										cur_mode = dlas_pkg::MODE_HOVER;
									end
								end
							end
							dlas_pkg::MODE_HOVER, dlas_pkg::MODE_ARMED: begin
								if (!it.armed) begin
									clear_hv();
									cur_mode = dlas_pkg::MODE_IDLE;
								end else if (it.roll_rate > rate_lim || it.pitch_rate > rate_lim
										|| it.yaw_rate > rate_lim) begin
									clear_hv();
								end else if (!hv_pend) begin
									hv_pend  = 1;
									hv_start = it.now_us;
								end else if (span_done(it.now_us, hv_start, hv_span)) begin
									clear_hv();
									cur_mode = dlas_pkg::MODE_ARMED;
								end
							end
							dlas_pkg::MODE_HANDOFF: begin
								if (!it.armed)
									cur_mode = dlas_pkg::MODE_IDLE;
							end
							default: ;
						endcase
					end
				end
			endcase
			exp.mode                 = cur_mode;
			exp.accepted             = acc;
			exp.owns_arming          = cur_mode == dlas_pkg::MODE_ARMACQ
				|| cur_mode == dlas_pkg::MODE_HOVER || cur_mode == dlas_pkg::MODE_ARMED
				|| cur_mode == dlas_pkg::MODE_HANDOFF;
			exp.suppress_pilot_input = cur_mode == dlas_pkg::MODE_AUTH
				|| cur_mode == dlas_pkg::MODE_RELWAIT || cur_mode == dlas_pkg::MODE_ARMACQ
				|| cur_mode == dlas_pkg::MODE_HOVER || cur_mode == dlas_pkg::MODE_ARMED;
			exp.wants_angle          = cur_mode == dlas_pkg::MODE_HOVER
				|| cur_mode == dlas_pkg::MODE_ARMED || cur_mode == dlas_pkg::MODE_HANDOFF;
			exp.wants_alt_pos_hold   = cur_mode == dlas_pkg::MODE_ARMED;
			exp.suppress_pilot_hold  = exp.wants_angle;
			exp.arm_request          = req;
			expected_q.push_back(exp);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		task field_check(string name, logic [2:0] got, logic [2:0] want);
			if (got !== want)
				report(name, 16'(got), 16'(want));
		endtask

		task check_result(logic [15:0] word);
			dlas_pkg::result_t got;
			dlas_pkg::result_t exp;
			got = dlas_pkg::result_t'(word[9:0]);
			if (expected_q.size() == 0) begin
				report("word with nothing expected", word, 16'h0);
				return;
			end
			exp = expected_q.pop_front();
			field_check("mode", got.mode, exp.mode);
			field_check("accepted", 3'(got.accepted), 3'(exp.accepted));
			field_check("owns_arming", 3'(got.owns_arming), 3'(exp.owns_arming));
			field_check("suppress_pilot_input", 3'(got.suppress_pilot_input),
				3'(exp.suppress_pilot_input));
			field_check("wants_angle", 3'(got.wants_angle), 3'(exp.wants_angle));
			field_check("wants_alt_pos_hold", 3'(got.wants_alt_pos_hold),
				3'(exp.wants_alt_pos_hold));
			field_check("suppress_pilot_hold", 3'(got.suppress_pilot_hold),
				3'(exp.suppress_pilot_hold));
			field_check("arm_request", 3'(got.arm_request), 3'(exp.arm_request));
			if (word[15:10] !== 6'h0)
				report("pad bits", word, 16'h0);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [30:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	seq_scoreboard              sb;
	int                         send_idle_pct;
	int                         recv_idle_pct;
	logic                       hold_go;
	int                         hold_left = 0;
	bit                         hold_used = 1'b0;
	int                         stall_cycles = 0;
	logic [dlas_pkg::TimeW-1:0] now_t;
	int unsigned                tstep;

	drop_launch_arming_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	// receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			m_tready  <= 1'b0;
			hold_left <= 80;
			hold_used <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic dlas_pkg::item_t mk(dlas_pkg::action_t a, logic [31:0] t, bit arm,
			bit fs, bit av, logic [13:0] mag, logic [11:0] rr, logic [11:0] pr,
			logic [11:0] yr, bit ok);
		dlas_pkg::item_t it;
		it.action      = a;
		it.now_us      = t;
		it.armed       = arm;
		it.failsafe    = fs;
		it.accel_valid = av;
		it.accel_mag   = mag;
		it.roll_rate   = rr;
		it.pitch_rate  = pr;
		it.yaw_rate    = yr;
		it.arm_try_ok  = ok;
		return it;
	endfunction

	function automatic logic [11:0] pick_rate(logic [11:0] lim);
		if ($urandom_range(0, 9) != 0)
			return 12'($urandom_range(0, lim));
		return 12'($urandom_range(0, 4000));
	endfunction

	task automatic send_word(dlas_pkg::item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.action;
		s_tdata  <= {2'b00, it.arm_try_ok, it.yaw_rate, it.pitch_rate, it.roll_rate,
			it.accel_mag, it.accel_valid, it.failsafe, it.armed, it.now_us};
		do @(posedge clk); while (!s_tready);
		sb.note_input(it);
	endtask

	task automatic write_reg(dlas_pkg::reg_idx_t idx, logic [30:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic write_config(logic [13:0] thr, logic [30:0] ff, logic [30:0] hv,
			logic [11:0] lim);
		logic [30:0] mx;
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(dlas_pkg::REG_FF_THRESH, {17'h0, thr});
		write_reg(dlas_pkg::REG_FF_CONFIRM, ff);
		write_reg(dlas_pkg::REG_HOVER_SPAN, hv);
		write_reg(dlas_pkg::REG_RATE_LIMIT, {19'h0, lim});
		cfg_wr_en <= 1'b0;
		mx    = (ff > hv) ? ff : hv;
		tstep = (mx > 90000) ? 30000 : mx / 3 + 1;
	endtask

	// mostly well-formed launch sequences steered by the predicted mode
	task automatic make_flight_item(output dlas_pkg::item_t it);
		int r;
		int pick;
		r    = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (pick < 5)
			now_t = now_t + ((sb.cur_mode == dlas_pkg::MODE_RELWAIT) ? sb.ff_span : sb.hv_span);
		else if (pick < 8)
			now_t = now_t - $urandom_range(1, 100000);
		else if (pick < 10)
			now_t = $urandom;
		else
			now_t = now_t + $urandom_range(0, tstep);
		it = mk(dlas_pkg::action_t'($urandom_range(0, 3)), now_t, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			14'($urandom_range(0, 16000)), 12'($urandom_range(0, 4000)),
			12'($urandom_range(0, 4000)), 12'($urandom_range(0, 4000)),
			1'($urandom_range(0, 1)));
		if (r < 85) begin
			it.failsafe = 1'b0;
			case (sb.cur_mode)
				dlas_pkg::MODE_IDLE: begin
					it.action = dlas_pkg::ACT_AUTH;
					it.armed  = 1'b0;
				end
				dlas_pkg::MODE_AUTH: begin
					it.action = dlas_pkg::ACT_RELEASE;
					it.armed  = 1'b0;
				end
				dlas_pkg::MODE_RELWAIT: begin
					it.action      = dlas_pkg::ACT_UPDATE;
					it.accel_valid = ($urandom_range(0, 19) != 0);
					it.armed       = ($urandom_range(0, 9) == 0);
					if ($urandom_range(0, 99) < 85)
						it.accel_mag = (sb.ff_thr == 0) ? 14'd0 :
							14'($urandom_range(0, sb.ff_thr - 1));
					else
						it.accel_mag = 14'($urandom_range(sb.ff_thr, 16000));
				end
				dlas_pkg::MODE_ARMACQ: begin
					it.action     = dlas_pkg::ACT_UPDATE;
					it.armed      = ($urandom_range(0, 3) == 0);
					it.arm_try_ok = ($urandom_range(0, 9) < 4);
				end
				dlas_pkg::MODE_HOVER, dlas_pkg::MODE_ARMED: begin
					it.action     = dlas_pkg::ACT_UPDATE;
					it.armed      = ($urandom_range(0, 99) < 97);
					it.roll_rate  = pick_rate(sb.rate_lim);
					it.pitch_rate = pick_rate(sb.rate_lim);
					it.yaw_rate   = pick_rate(sb.rate_lim);
				end
				default: begin
					it.action = dlas_pkg::ACT_UPDATE;
					it.armed  = ($urandom_range(0, 4) != 0);
				end
			endcase
		end else if (r < 90) begin
			it.action = dlas_pkg::ACT_ABORT;
		end else if (r < 93) begin
			it.action   = dlas_pkg::ACT_UPDATE;
			it.failsafe = 1'b1;
		end
	endtask

	initial begin
		dlas_pkg::item_t it;
		int              n;
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_addr      = dlas_pkg::REG_FF_THRESH;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = dlas_pkg::ACT_UPDATE;
		hold_go       = 1'b0;
		send_idle_pct = 6;
		recv_idle_pct = 88;
		now_t         = 32'h0010_0000;
		tstep         = 30000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through the sequence at reset settings
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd0, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 1));
		send_word(mk(dlas_pkg::ACT_AUTH, 32'hFFFF_FFFF, 1, 0, 1, 14'd16000, 12'd4000,
			12'd4000, 12'd4000, 1));
		send_word(mk(dlas_pkg::ACT_AUTH, 32'd10, 0, 1, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_RELEASE, 32'd20, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_AUTH, 32'd30, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_AUTH, 32'd40, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_RELEASE, 32'd50, 1, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_RELEASE, 32'd60, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd1000, 0, 0, 1, 14'd100, 12'd0, 12'd0, 12'd0,
			0));
		// time running backward never confirms
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd500, 0, 0, 1, 14'd100, 12'd0, 12'd0, 12'd0,
			0));
		// freefall confirmed while already armed stays in release wait
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd101000, 1, 0, 1, 14'd100, 12'd0, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd200000, 0, 0, 1, 14'd100, 12'd0, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd250000, 0, 0, 1, 14'd16000, 12'd0, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd260000, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0,
			0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd300000, 0, 0, 1, 14'd0, 12'd0, 12'd0, 12'd0,
			0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd400000, 0, 0, 1, 14'd299, 12'd0, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd400100, 0, 0, 1, 14'd0, 12'd0, 12'd0, 12'd0,
			0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd400200, 0, 0, 1, 14'd0, 12'd0, 12'd0, 12'd0,
			1));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd400300, 1, 0, 1, 14'd0, 12'd4000, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'hFFFF_0000, 1, 0, 1, 14'd0, 12'd30, 12'd30,
			12'd30, 0));
		// hover timer across the 32-bit wrap
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'hFFFF_0000 + 32'd500000, 1, 0, 1, 14'd0,
			12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd5, 1, 1, 1, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'd6, 1, 0, 1, 14'd0, 12'd0, 12'd0, 12'd0, 1));
		send_word(mk(dlas_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 0, 0, 1, 14'd0, 12'd0, 12'd0,
			12'd0, 0));
		send_word(mk(dlas_pkg::ACT_ABORT, 32'd7, 1, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_AUTH, 32'd8, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));
		send_word(mk(dlas_pkg::ACT_ABORT, 32'd9, 0, 0, 0, 14'd0, 12'd0, 12'd0, 12'd0, 0));

		n = 0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_config(14'd16000, 31'd0, 31'd0, 12'd4000);
				1: write_config(14'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 12'd0);
				6: write_config(14'($urandom_range(1, 16000)), 31'($urandom & 32'h7FFF_FFFF),
					31'($urandom & 32'h7FFF_FFFF), 12'($urandom_range(0, 4000)));
				7: write_config(dlas_pkg::FfThreshReset, dlas_pkg::FfConfirmReset,
					dlas_pkg::HoverSpanReset, dlas_pkg::RateLimitReset);
				default: write_config(14'($urandom_range(1, 16000)),
					31'($urandom_range(0, 3000)), 31'($urandom_range(0, 3000)),
					12'($urandom_range(0, 4000)));
			endcase
			for (int i = 0; i < PhaseItems; i++) begin
				if (n < 520) begin
					send_idle_pct = 6;
					recv_idle_pct = 88;
				end else if (n < 1040) begin
					send_idle_pct = 88;
					recv_idle_pct = 6;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					if (n == 1040)
						hold_go <= 1'b1;
				end
				make_flight_item(it);
				send_word(it);
				n++;
			end
		end

		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
